// ===== rtl/core/lprct_pkg.sv =====
`timescale 1ns / 1ps

package lprct_pkg;

    // Field widths of the point and result beats.
    localparam int COORD_BITS = 20;
    localparam int REFL_W     = 16;
    localparam int RING_W     = 8;
    localparam int COL_W      = 16;
    localparam int TIME_W     = 20;

    // Default number of CORDIC micro-rotations.
    localparam int CORDIC_STEPS_DEF = 20;

    // Angles are held in 1/256 centidegree units.
    localparam int ANG_W    = 25;
    localparam int ANG_FRAC = 8;
    localparam logic signed [ANG_W-1:0] ANG_180 = 25'sd4608000;
    localparam logic signed [ANG_W-1:0] ANG_360 = 25'sd9216000;

    // CORDIC datapath.
    localparam int CO_IN_W  = COORD_BITS + 1;
    localparam int CO_W     = 64;
    localparam int PRESHIFT = 60 - COORD_BITS;

    // Width of the ring and column dividends.
    localparam int DIV_W = 16;

    // Ring saturation.
    localparam logic [RING_W-1:0] RING_MAX = 8'h7f;
    localparam logic [RING_W-1:0] RING_MIN = 8'h80;
    localparam logic [DIV_W-1:0]  RING_LIM = 16'd128;

    // Configuration registers.
    localparam int ADDR_W = 5;
    localparam int BOT_W  = 14;
    localparam int VRES_W = 14;
    localparam int HRES_W = 12;
    localparam int CCNT_W = 13;
    localparam int SCAN_W = 20;

    localparam logic [2:0] REG_BOTTOM = 3'd0;
    localparam logic [2:0] REG_VRES   = 3'd1;
    localparam logic [2:0] REG_HRES   = 3'd2;
    localparam logic [2:0] REG_CCOUNT = 3'd3;
    localparam logic [2:0] REG_SCAN   = 3'd4;

    localparam logic [BOT_W-1:0]  BOT_RST  = 14'd1510;
    localparam logic [VRES_W-1:0] VRES_RST = 14'd200;
    localparam logic [HRES_W-1:0] HRES_RST = 12'd20;
    localparam logic [CCNT_W-1:0] CCNT_RST = 13'd1800;
    localparam logic [SCAN_W-1:0] SCAN_RST = 20'd100000;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic [REFL_W-1:0]            reflectivity;
        logic                         point_valid;
    } t_in_beat;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic signed [COORD_BITS-1:0] out_z;
        logic [REFL_W-1:0]            out_reflectivity;
        logic signed [RING_W-1:0]     ring_index;
        logic [COL_W-1:0]             column_index;
        logic [TIME_W-1:0]            point_time_us;
        logic                         range_clipped;
    } t_out_beat;

    // atan(2^-i) in angle units, rounded to nearest.
    function automatic logic signed [ANG_W-1:0] atan_ang(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:  v = 25'sd1152000;
            1:  v = 25'sd680065;
            2:  v = 25'sd359328;
            3:  v = 25'sd182400;
            4:  v = 25'sd91554;
            5:  v = 25'sd45822;
            6:  v = 25'sd22916;
            7:  v = 25'sd11459;
            8:  v = 25'sd5730;
            9:  v = 25'sd2865;
            10: v = 25'sd1432;
            11: v = 25'sd716;
            12: v = 25'sd358;
            13: v = 25'sd179;
            14: v = 25'sd90;
            15: v = 25'sd45;
            16: v = 25'sd22;
            17: v = 25'sd11;
            18: v = 25'sd6;
            19: v = 25'sd3;
            20: v = 25'sd1;
            21: v = 25'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/lprct_div.sv =====
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per stage.
// The starting remainder must be below the divisor.
module lprct_div #(
    parameter int DVD_W = 16,
    parameter int DSR_W = 14
) (
    input  logic             i_clk,
    input  logic [DSR_W-1:0] i_rem,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DSR_W-1:0] i_divisor,
    output logic [DVD_W-1:0] o_quot
);

    logic [DSR_W-1:0] r_rem [0:DVD_W-1];
    logic [DVD_W-1:0] r_dvd [0:DVD_W-1];
    logic [DVD_W-1:0] r_quo [0:DVD_W-1];

    genvar k;
    generate
        for (k = 0; k < DVD_W; k++) begin : g_stage
            logic [DSR_W-1:0] rem_in;
            logic [DVD_W-1:0] dvd_in;
            logic [DVD_W-1:0] quo_in;
            logic [DSR_W:0]   cand;
            logic             take;

            if (k == 0) begin : g_first
                assign rem_in = i_rem;
                assign dvd_in = i_dividend;
                assign quo_in = '0;
            end else begin : g_next
                assign rem_in = r_rem[k-1];
                assign dvd_in = r_dvd[k-1];
                assign quo_in = r_quo[k-1];
            end

            // Bring down the next dividend bit and try to subtract.
            assign cand = {rem_in, dvd_in[DVD_W-1]};
            assign take = (cand >= {1'b0, i_divisor});

            always_ff @(posedge i_clk) begin
                r_rem[k] <= take ? DSR_W'(cand - {1'b0, i_divisor}) : cand[DSR_W-1:0];
                r_dvd[k] <= dvd_in << 1;
                r_quo[k] <= {quo_in[DVD_W-2:0], take};
            end
        end
    endgenerate

    assign o_quot = r_quo[DVD_W-1];

endmodule

// ===== rtl/core/lprct_cordic.sv =====
`timescale 1ns / 1ps

// Pipelined vectoring CORDIC giving atan2(y, x) in 1/256 centidegree units.
// One register for the quadrant fold, then one per micro-rotation.
module lprct_cordic #(
    parameter int STEPS = lprct_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                 i_clk,
    input  logic signed [lprct_pkg::CO_IN_W-1:0] i_x,
    input  logic signed [lprct_pkg::CO_IN_W-1:0] i_y,
    output logic signed [lprct_pkg::ANG_W-1:0]   o_ang
);

    localparam int W  = lprct_pkg::CO_W;
    localparam int IW = lprct_pkg::CO_IN_W;

    logic signed [W-1:0]                   r_vx   [0:STEPS];
    logic signed [W-1:0]                   r_vy   [0:STEPS];
    logic signed [lprct_pkg::ANG_W-1:0]    r_ang  [0:STEPS];
    logic                                  r_zero [0:STEPS];

    logic signed [W-1:0] xe;
    logic signed [W-1:0] ye;
    logic                xneg;

    assign xe   = {{(W-IW){i_x[IW-1]}}, i_x};
    assign ye   = {{(W-IW){i_y[IW-1]}}, i_y};
    assign xneg = i_x[IW-1];

    // Fold the left half plane onto the right one and scale up.
    always_ff @(posedge i_clk) begin
        r_vx[0]   <= (xneg ? -xe : xe) <<< lprct_pkg::PRESHIFT;
        r_vy[0]   <= (xneg ? -ye : ye) <<< lprct_pkg::PRESHIFT;
        r_zero[0] <= (i_x == '0) && (i_y == '0);
        if (xneg) begin
            r_ang[0] <= i_y[IW-1] ? -lprct_pkg::ANG_180 : lprct_pkg::ANG_180;
        end else begin
            r_ang[0] <= '0;
        end
    end

    genvar i;
    generate
        for (i = 0; i < STEPS; i++) begin : g_rot
            logic signed [W-1:0] sx;
            logic signed [W-1:0] sy;
            logic                up;

            assign sx = r_vx[i] >>> i;
            assign sy = r_vy[i] >>> i;
            assign up = ~r_vy[i][W-1];

            // Rotate towards the x axis and accumulate the angle.
            always_ff @(posedge i_clk) begin
                r_vx[i+1]   <= up ? r_vx[i] + sy : r_vx[i] - sy;
                r_vy[i+1]   <= up ? r_vy[i] - sx : r_vy[i] + sx;
                r_ang[i+1]  <= up ? r_ang[i] + lprct_pkg::atan_ang(i)
                                  : r_ang[i] - lprct_pkg::atan_ang(i);
                r_zero[i+1] <= r_zero[i];
            end
        end
    endgenerate

    assign o_ang = r_zero[STEPS] ? '0 : r_ang[STEPS];

endmodule

// ===== rtl/core/lidar_point_ring_column_time.sv =====
`timescale 1ns / 1ps

// A point accepted with start high gives its result strobe after the square-root,
// CORDIC, divider and firing-time stages and the output register.
// Throughput: one point per cycle; busy never rises and invalid points give no beat.
// The pipeline length is set by the square-root, CORDIC and divider stages, one bit or step each.
// Reset is synchronous and clears the pipeline valids and the registers to their defaults.
module lidar_point_ring_column_time #(
    parameter int CORDIC_STEPS = lprct_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  lprct_pkg::t_in_beat            i_point,
    output logic                           o_strobe,
    output lprct_pkg::t_out_beat           o_result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lprct_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int C      = lprct_pkg::COORD_BITS;
    localparam int SQ_W   = 2 * C + 1;
    localparam int DIV_W  = lprct_pkg::DIV_W;
    localparam int TIME_W = lprct_pkg::TIME_W;
    localparam int PROD_W = lprct_pkg::COL_W + lprct_pkg::SCAN_W;
    localparam int ANG_W  = lprct_pkg::ANG_W;
    localparam int FRAC   = lprct_pkg::ANG_FRAC;

    localparam int ST_SQ_END = 3 + C;
    localparam int ST_CO_END = ST_SQ_END + CORDIC_STEPS + 1;
    localparam int ST_TD_END = ST_CO_END + 1 + DIV_W + 1 + TIME_W;

    typedef struct packed {
        logic signed [C-1:0]            x;
        logic signed [C-1:0]            y;
        logic signed [C-1:0]            z;
        logic [lprct_pkg::REFL_W-1:0]   refl;
    } t_pay;

    typedef struct packed {
        logic [lprct_pkg::RING_W-1:0]   ring;
        logic [lprct_pkg::COL_W-1:0]    col;
        logic                           clip;
    } t_mtag;

    typedef struct packed {
        logic [lprct_pkg::RING_W-1:0]   ring;
        logic [lprct_pkg::COL_W-1:0]    col;
        logic                           clip;
        logic                           sat;
    } t_tag;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    logic [lprct_pkg::BOT_W-1:0]  r_bottom;
    logic [lprct_pkg::VRES_W-1:0] r_vres;
    logic [lprct_pkg::HRES_W-1:0] r_hres;
    logic [lprct_pkg::CCNT_W-1:0] r_ccount;
    logic [lprct_pkg::SCAN_W-1:0] r_scan;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel & penable & pwrite & pready;

    // Register writes; an unknown address is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bottom <= lprct_pkg::BOT_RST;
            r_vres   <= lprct_pkg::VRES_RST;
            r_hres   <= lprct_pkg::HRES_RST;
            r_ccount <= lprct_pkg::CCNT_RST;
            r_scan   <= lprct_pkg::SCAN_RST;
        end else if (cfg_wr) begin
            case (paddr[lprct_pkg::ADDR_W-1:2])
                lprct_pkg::REG_BOTTOM: begin
                    r_bottom <= pwdata[lprct_pkg::BOT_W-1:0];
                end
                lprct_pkg::REG_VRES: begin
                    r_vres <= pwdata[lprct_pkg::VRES_W-1:0];
                end
                lprct_pkg::REG_HRES: begin
                    r_hres <= pwdata[lprct_pkg::HRES_W-1:0];
                end
                lprct_pkg::REG_CCOUNT: begin
                    r_ccount <= pwdata[lprct_pkg::CCNT_W-1:0];
                end
                lprct_pkg::REG_SCAN: begin
                    r_scan <= pwdata[lprct_pkg::SCAN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (paddr[lprct_pkg::ADDR_W-1:2])
            lprct_pkg::REG_BOTTOM: prdata = 32'(r_bottom);
            lprct_pkg::REG_VRES:   prdata = 32'(r_vres);
            lprct_pkg::REG_HRES:   prdata = 32'(r_hres);
            lprct_pkg::REG_CCOUNT: prdata = 32'(r_ccount);
            lprct_pkg::REG_SCAN:   prdata = 32'(r_scan);
            default:               prdata = '0;
        endcase
    end

    // A zero divisor counts as one.
    logic [lprct_pkg::VRES_W-1:0] vres1;
    logic [lprct_pkg::HRES_W-1:0] hres1;
    logic [lprct_pkg::CCNT_W-1:0] ccount1;

    assign vres1   = (r_vres == '0) ? lprct_pkg::VRES_W'(1) : r_vres;
    assign hres1   = (r_hres == '0) ? lprct_pkg::HRES_W'(1) : r_hres;
    assign ccount1 = (r_ccount == '0) ? lprct_pkg::CCNT_W'(1) : r_ccount;

    // ------------------------------------------------------------------
    // Valid bits and the point payload travel down one delay line.
    // ------------------------------------------------------------------
    logic r_vld [1:ST_TD_END];
    t_pay r_pay [1:ST_TD_END];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= ST_TD_END; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[1] <= start & ~busy & i_point.point_valid;
            for (int s = 2; s <= ST_TD_END; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pay[1] <= '{x: i_point.pos_x, y: i_point.pos_y, z: i_point.pos_z,
                      refl: i_point.reflectivity};
        for (int s = 2; s <= ST_TD_END; s++) begin
            r_pay[s] <= r_pay[s-1];
        end
    end

    // ------------------------------------------------------------------
    // Horizontal radius: squares, sum, then a bit-per-stage square root.
    // ------------------------------------------------------------------
    logic [C-1:0]   ax;
    logic [C-1:0]   ay;
    logic [2*C-1:0] r_sqx;
    logic [2*C-1:0] r_sqy;
    logic [2*C-1:0] r_sum;

    assign ax = r_pay[1].x[C-1] ? C'(-r_pay[1].x) : r_pay[1].x;
    assign ay = r_pay[1].y[C-1] ? C'(-r_pay[1].y) : r_pay[1].y;

    always_ff @(posedge i_clk) begin
        r_sqx <= ax * ax;
        r_sqy <= ay * ay;
        r_sum <= r_sqx + r_sqy;
    end

    logic [SQ_W-1:0] r_sqn   [0:C-1];
    logic [SQ_W-1:0] r_sqres [0:C-1];

    genvar k;
    generate
        for (k = 0; k < C; k++) begin : g_sqrt
            localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (C - 1 - k));
            logic [SQ_W-1:0] n_in;
            logic [SQ_W-1:0] res_in;
            logic [SQ_W-1:0] trial;
            logic            take;

            if (k == 0) begin : g_first
                assign n_in   = SQ_W'(r_sum);
                assign res_in = '0;
            end else begin : g_next
                assign n_in   = r_sqn[k-1];
                assign res_in = r_sqres[k-1];
            end

            assign trial = res_in + BIT;
            assign take  = (n_in >= trial);

            always_ff @(posedge i_clk) begin
                r_sqn[k]   <= take ? n_in - trial : n_in;
                r_sqres[k] <= take ? (res_in >> 1) + BIT : res_in >> 1;
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Elevation and azimuth angles.
    // ------------------------------------------------------------------
    logic [C-1:0]                            root;
    logic signed [lprct_pkg::CO_IN_W-1:0]    el_x;
    logic signed [lprct_pkg::CO_IN_W-1:0]    el_y;
    logic signed [lprct_pkg::CO_IN_W-1:0]    az_x;
    logic signed [lprct_pkg::CO_IN_W-1:0]    az_y;
    logic signed [ANG_W-1:0]                 elev;
    logic signed [ANG_W-1:0]                 az;

    assign root = r_sqres[C-1][C-1:0];
    assign el_x = {1'b0, root};
    assign el_y = {r_pay[ST_SQ_END].z[C-1], r_pay[ST_SQ_END].z};
    assign az_x = {r_pay[ST_SQ_END].x[C-1], r_pay[ST_SQ_END].x};
    assign az_y = {r_pay[ST_SQ_END].y[C-1], r_pay[ST_SQ_END].y};

    lprct_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic_elev (
        .i_clk (i_clk),
        .i_x   (el_x),
        .i_y   (el_y),
        .o_ang (elev)
    );

    lprct_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic_az (
        .i_clk (i_clk),
        .i_x   (az_x),
        .i_y   (az_y),
        .o_ang (az)
    );

    // ------------------------------------------------------------------
    // Offset the elevation, wrap the azimuth and form the dividends.
    // ------------------------------------------------------------------
    logic signed [ANG_W-1:0] num;
    logic signed [ANG_W-1:0] anum;
    logic signed [ANG_W-1:0] az_w;
    logic signed [ANG_W-1:0] col_num;
    logic [DIV_W-1:0]        r_p_ring_dvd;
    logic [DIV_W-1:0]        r_p_col_dvd;
    logic                    r_neg [0:DIV_W];

    assign num     = elev + ANG_W'({r_bottom, {FRAC{1'b0}}});
    assign anum    = num[ANG_W-1] ? -num : num;
    assign az_w    = az[ANG_W-1] ? az + lprct_pkg::ANG_360 : az;
    assign col_num = az_w + ANG_W'({hres1, {(FRAC-1){1'b0}}});

    always_ff @(posedge i_clk) begin
        r_p_ring_dvd <= anum[DIV_W+FRAC-1:FRAC];
        r_p_col_dvd  <= col_num[DIV_W+FRAC-1:FRAC];
        r_neg[0]     <= num[ANG_W-1];
        for (int s = 1; s <= DIV_W; s++) begin
            r_neg[s] <= r_neg[s-1];
        end
    end

    logic [DIV_W-1:0] ring_q;
    logic [DIV_W-1:0] col_q;

    lprct_div #(
        .DVD_W (DIV_W),
        .DSR_W (lprct_pkg::VRES_W)
    ) u_div_ring (
        .i_clk      (i_clk),
        .i_rem      ('0),
        .i_dividend (r_p_ring_dvd),
        .i_divisor  (vres1),
        .o_quot     (ring_q)
    );

    lprct_div #(
        .DVD_W (DIV_W),
        .DSR_W (lprct_pkg::HRES_W)
    ) u_div_col (
        .i_clk      (i_clk),
        .i_rem      ('0),
        .i_dividend (r_p_col_dvd),
        .i_divisor  (hres1),
        .o_quot     (col_q)
    );

    // ------------------------------------------------------------------
    // Ring saturation and the column times scan period product.
    // ------------------------------------------------------------------
    logic                         ring_big;
    logic [lprct_pkg::RING_W-1:0] ring_lo;
    logic [lprct_pkg::RING_W-1:0] ring_val;
    logic [PROD_W-1:0]            r_m_prod;
    t_mtag                        r_m_tag;

    assign ring_big = (ring_q >= lprct_pkg::RING_LIM);
    assign ring_lo  = ring_q[lprct_pkg::RING_W-1:0];

    always_comb begin
        if (r_neg[DIV_W]) begin
            ring_val = ring_big ? lprct_pkg::RING_MIN : ~ring_lo + 1'b1;
        end else begin
            ring_val = ring_big ? lprct_pkg::RING_MAX : ring_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_prod <= col_q * r_scan;
        r_m_tag  <= '{ring: ring_val, col: col_q, clip: ~r_neg[DIV_W] & ring_big};
    end

    // ------------------------------------------------------------------
    // Firing time: the bits above the result width decide saturation,
    // the remaining twenty come from the divider.
    // ------------------------------------------------------------------
    logic             sat;
    logic [TIME_W-1:0] time_q;
    t_tag             r_tag [1:TIME_W];

    assign sat = (r_m_prod[PROD_W-1:TIME_W] >= (PROD_W - TIME_W)'(ccount1));

    lprct_div #(
        .DVD_W (TIME_W),
        .DSR_W (lprct_pkg::CCNT_W)
    ) u_div_time (
        .i_clk      (i_clk),
        .i_rem      (r_m_prod[TIME_W+lprct_pkg::CCNT_W-1:TIME_W]),
        .i_dividend (r_m_prod[TIME_W-1:0]),
        .i_divisor  (ccount1),
        .o_quot     (time_q)
    );

    always_ff @(posedge i_clk) begin
        r_tag[1] <= '{ring: r_m_tag.ring, col: r_m_tag.col, clip: r_m_tag.clip, sat: sat};
        for (int s = 2; s <= TIME_W; s++) begin
            r_tag[s] <= r_tag[s-1];
        end
    end

    // ------------------------------------------------------------------
    // Result beat.
    // ------------------------------------------------------------------
    logic                 r_strobe;
    lprct_pkg::t_out_beat r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vld[ST_TD_END];
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.out_x            <= r_pay[ST_TD_END].x;
        r_result.out_y            <= r_pay[ST_TD_END].y;
        r_result.out_z            <= r_pay[ST_TD_END].z;
        r_result.out_reflectivity <= r_pay[ST_TD_END].refl;
        r_result.ring_index       <= r_tag[TIME_W].ring;
        r_result.column_index     <= r_tag[TIME_W].col;
        r_result.point_time_us    <= r_tag[TIME_W].sat ? '1 : time_q;
        r_result.range_clipped    <= r_tag[TIME_W].clip | r_tag[TIME_W].sat;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== tb/sv/lidar_point_ring_column_time_tb.sv =====
`timescale 1ns / 1ps

module lidar_point_ring_column_time_tb;

    import lprct_pkg::*;

    localparam int  ROT_STEPS = CORDIC_STEPS_DEF;
    localparam int  DRAIN_CYCLES = 120;
    localparam int  ITEMS_PER_PHASE = 170;
    localparam longint signed HALF_TURN = 64'sd4608000;
    localparam longint signed FULL_TURN = 64'sd9216000;
    localparam logic [ADDR_W-1:0] ADDR_UNUSED = 5'd20;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in_beat i_point = '0;
    logic o_strobe;
    t_out_beat o_result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // Shadow copy of the configuration registers.
    logic [BOT_W-1:0]  cfg_bottom;
    logic [VRES_W-1:0] cfg_vres;
    logic [HRES_W-1:0] cfg_hres;
    logic [CCNT_W-1:0] cfg_ccount;
    logic [SCAN_W-1:0] cfg_scan;

    t_in_beat  pending_points[$];
    t_out_beat expected_tags[$];
    int        sender_idle_pct = 0;
    int        mismatch_count = 0;

    longint signed atan_lut [32] = '{
        1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
        5730, 2865, 1432, 716, 358, 179, 90, 45,
        22, 11, 6, 3, 1, 1, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    lidar_point_ring_column_time dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_point (i_point),
        .o_strobe(o_strobe),
        .o_result(o_result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Floor square root of a non-negative integer, one result bit per pass.
    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Vectoring rotations towards the x axis; vx must be non-negative.
    function automatic longint signed vector_angle(longint signed vx, longint signed vy);
        longint signed ang;
        longint signed sx;
        longint signed sy;
        ang = 0;
        for (int i = 0; i < ROT_STEPS && i < 32; i++) begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy >= 0) begin
                vx = vx + sy;
                vy = vy - sx;
                ang = ang + atan_lut[i];
            end else begin
                vx = vx - sy;
                vy = vy + sx;
                ang = ang - atan_lut[i];
            end
        end
        return ang;
    endfunction

    function automatic longint signed fixed_atan2(longint signed y, longint signed x);
        longint signed scale;
        scale = 64'sd1 <<< PRESHIFT;
        if (x == 0 && y == 0) return 0;
        if (x >= 0) return vector_angle(x * scale, y * scale);
        if (y >= 0) return HALF_TURN + vector_angle(-x * scale, -y * scale);
        return -HALF_TURN + vector_angle(-x * scale, -y * scale);
    endfunction

    // Works out the tags of one point; returns 0 where the point is dropped.
    function automatic bit tag_point(t_in_beat p, output t_out_beat t);
        longint signed x, y, z, elev, az, num, den, ring;
        longint unsigned ax, ay, r, anum, q, col, tim, hres, ccount;
        bit clip;
        t = '0;
        clip = 1'b0;
        if (!p.point_valid) return 1'b0;
        x = longint'(p.pos_x);
        y = longint'(p.pos_y);
        z = longint'(p.pos_z);
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        r = floor_sqrt(ax * ax + ay * ay);

        // Ring from the elevation angle.
        elev = fixed_atan2(z, longint'(r));
        num = elev + longint'(cfg_bottom) * 256;
        den = longint'((cfg_vres != 0) ? cfg_vres : 1) * 256;
        anum = (num < 0) ? -num : num;
        q = anum / den;
        if (q > 128) q = 128;
        ring = (num < 0) ? -longint'(q) : longint'(q);
        if (ring > 127) begin
            ring = 127;
            clip = 1'b1;
        end

        // Column from the azimuth, wrapped into one revolution.
        az = fixed_atan2(y, x);
        if (az < 0) az = az + FULL_TURN;
        if (az < 0) az = 0;
        hres = (cfg_hres != 0) ? cfg_hres : 1;
        col = (longint'(az) + hres * 128) / (hres * 256);
        if (col > 65535) begin
            col = 65535;
            clip = 1'b1;
        end

        // Firing time of the column.
        ccount = (cfg_ccount != 0) ? cfg_ccount : 1;
        tim = col * longint'(cfg_scan) / ccount;
        if (tim > 1048575) begin
            tim = 1048575;
            clip = 1'b1;
        end

        t.out_x = p.pos_x;
        t.out_y = p.pos_y;
        t.out_z = p.pos_z;
        t.out_reflectivity = p.reflectivity;
        t.ring_index = ring[RING_W-1:0];
        t.column_index = col[COL_W-1:0];
        t.point_time_us = tim[TIME_W-1:0];
        t.range_clipped = clip;
        return 1'b1;
    endfunction

    // Driver: presents queued points, with random gaps between beats.
    always @(posedge i_clk) begin
        t_out_beat t;
        if (i_rst_n && start && !busy) begin
            if (tag_point(i_point, t)) expected_tags.insert(expected_tags.size(), t);
        end
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (pending_points.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                i_point <= pending_points.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: each result beat is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_beat e;
        if (i_rst_n && o_strobe) begin
            if (expected_tags.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result beat %p", o_result);
            end else begin
                e = expected_tags.pop_front();
                if (o_result.out_x !== e.out_x || o_result.out_y !== e.out_y ||
                    o_result.out_z !== e.out_z ||
                    o_result.out_reflectivity !== e.out_reflectivity ||
                    o_result.ring_index !== e.ring_index ||
                    o_result.column_index !== e.column_index ||
                    o_result.point_time_us !== e.point_time_us ||
                    o_result.range_clipped !== e.range_clipped) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected %p, got %p", e, o_result);
                end
            end
        end
    end

    // One register write: setup cycle, then access cycle until pready.
    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (addr[4:2])
            REG_BOTTOM: cfg_bottom = value[BOT_W-1:0];
            REG_VRES:   cfg_vres = value[VRES_W-1:0];
            REG_HRES:   cfg_hres = value[HRES_W-1:0];
            REG_CCOUNT: cfg_ccount = value[CCNT_W-1:0];
            REG_SCAN:   cfg_scan = value[SCAN_W-1:0];
            default: ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic write_all(int bot, int vres, int hres, int ccount, int scan);
        write_reg({REG_BOTTOM, 2'b00}, bot);
        write_reg({REG_VRES, 2'b00}, vres);
        write_reg({REG_HRES, 2'b00}, hres);
        write_reg({REG_CCOUNT, 2'b00}, ccount);
        write_reg({REG_SCAN, 2'b00}, scan);
    endtask

    task automatic add_point(int x, int y, int z, int refl, bit valid);
        t_in_beat p;
        p.pos_x = x;
        p.pos_y = y;
        p.pos_z = z;
        p.reflectivity = refl;
        p.point_valid = valid;
        pending_points.insert(pending_points.size(), p);
    endtask

    // Random points: full-range bits, short ranges, and points near the axes.
    task automatic add_random_points(int n);
        int sel;
        int span;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(3);
            span = (sel == 1) ? 3000 : 40;
            if (sel == 0)
                add_point($urandom, $urandom, $urandom, $urandom, $urandom_range(9) != 0);
            else if (sel == 3)
                add_point($urandom_range(2) == 0 ? 0 : $urandom,
                          $urandom_range(2) == 0 ? 0 : $urandom_range(span) - span / 2,
                          $urandom, $urandom, $urandom_range(9) != 0);
            else
                add_point($urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                          $urandom_range(2 * span) - span, $urandom,
                          $urandom_range(9) != 0);
        end
    endtask

    // Let every queued point be taken and every tagged result come back.
    task automatic drain();
        while (pending_points.size() > 0 || start || expected_tags.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        cfg_bottom = BOT_RST;
        cfg_vres = VRES_RST;
        cfg_hres = HRES_RST;
        cfg_ccount = CCNT_RST;
        cfg_scan = SCAN_RST;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values, with the corner points first.
        add_point(0, 0, 0, 0, 1'b1);
        add_point(524287, 524287, 524287, 16'hffff, 1'b1);
        add_point(-524288, -524288, -524288, 16'h5a5a, 1'b1);
        add_point(-1000, 0, 10, 1, 1'b1);
        add_point(-1000, -3, -10, 2, 1'b1);
        add_point(0, -700, 0, 3, 1'b1);
        add_point(0, 700, 0, 4, 1'b1);
        add_point(5000, -1, 0, 5, 1'b1);
        add_point(0, 0, 524287, 6, 1'b1);
        add_point(0, 0, -524288, 7, 1'b1);
        add_point(1, 0, -524287, 8, 1'b1);
        add_point(1234, 567, 89, 16'hffff, 1'b0);
        add_point(-524288, 524287, 0, 16'h8000, 1'b1);
        add_point(3, 4, 5, 9, 1'b1);
        add_random_points(ITEMS_PER_PHASE);
        drain();

        // Largest offset, finest resolutions and longest period: heavy clipping.
        write_all(9000, 1, 1, 1, 1048575);
        sender_idle_pct = 75;
        add_random_points(ITEMS_PER_PHASE);
        drain();

        // Coarsest settings, beyond the documented ranges where the widths allow.
        write_all(0, 16383, 4095, 8191, 1);
        sender_idle_pct = 0;
        add_random_points(ITEMS_PER_PHASE);
        drain();

        // Zero divisors fall back to one; a write past the last register is ignored.
        write_all(4500, 0, 0, 0, 1000000);
        write_reg(ADDR_UNUSED, 32'hffff_ffff);
        sender_idle_pct = 22;
        add_random_points(ITEMS_PER_PHASE);
        drain();

        // Random settings, with stray upper bits on the data bus.
        write_all($urandom, $urandom, $urandom, $urandom, $urandom);
        sender_idle_pct = 50;
        add_random_points(ITEMS_PER_PHASE);
        drain();

        if (mismatch_count == 0 && expected_tags.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Hard time limit on the whole run.
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/lprct_pkg.sv
rtl/core/lprct_div.sv
rtl/core/lprct_cordic.sv
rtl/core/lidar_point_ring_column_time.sv
tb/sv/lidar_point_ring_column_time_tb.sv
